[rtl/core/gwwp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwp_pkg
// Shared types, constants and helper functions of the greedy word-wrap
// paginator: record layout, layout counters, state vector and register map.
// ----------------------------------------------------------------------------
package gwwp_pkg;

	localparam int INDEX_BITS = 20;
	localparam int PAGE_BITS  = 12;

	// Character codes with a meaning of their own
	localparam logic [15:0] CHAR_SPACE   = 16'd32;
	localparam logic [15:0] CHAR_NEWLINE = 16'd10;

	// Register map, word index into the APB space
	localparam logic [1:0] REG_LINE_WIDTH       = 2'd0;
	localparam logic [1:0] REG_LINES_PER_COLUMN = 2'd1;
	localparam logic [1:0] REG_COLUMNS_PER_PAGE = 2'd2;

	localparam logic [7:0] RST_LINE_WIDTH       = 8'd10;
	localparam logic [7:0] RST_LINES_PER_COLUMN = 8'd5;
	localparam logic [4:0] RST_COLUMNS_PER_PAGE = 5'd4;

	localparam logic [4:0] MAX_COLUMNS = 5'd16;

	// One emitted line record
	typedef struct packed {
		logic [INDEX_BITS-1:0] start;
		logic [7:0]            chars;
		logic [PAGE_BITS-1:0]  page;
		logic [3:0]            column;
		logic [7:0]            row;
		logic                  last;
	} rec_t;

	// Page / column / row position of the next line
	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic [3:0]           column;
		logic [7:0]           row;
	} ctr_t;

	// Layout state carried from one character to the next
	typedef struct packed {
		logic [INDEX_BITS-1:0] char_position;
		logic [INDEX_BITS-1:0] open_line_start;
		logic [7:0]            open_line_used;
		logic [INDEX_BITS-1:0] word_start;
		logic [7:0]            word_chars;
		ctr_t                  ctr;
	} state_t;

	// Result of placing a word charge on the open line
	typedef struct packed {
		logic                  emit;
		logic [INDEX_BITS-1:0] emit_start;
		logic [7:0]            emit_len;
		logic [7:0]            used;
		logic [INDEX_BITS-1:0] line_start;
	} place_t;

	// Move the layout position on by one line
	function automatic ctr_t adv_ctr(input ctr_t c, input logic [7:0] rows,
			input logic [4:0] cols);
		ctr_t r;
		r = c;
		r.row = c.row + 8'd1;
		if (r.row >= rows) begin
			r.row = '0;
			r.column = c.column + 4'd1;
			if ({1'b0, r.column} >= cols) begin
				r.column = '0;
				r.page = c.page + PAGE_BITS'(1);
			end
		end
		return r;
	endfunction

	// Build a record at the current layout position
	function automatic rec_t mk_rec(input logic [INDEX_BITS-1:0] start,
			input logic [7:0] chars, input ctr_t c);
		rec_t r;
		r.start  = start;
		r.chars  = chars;
		r.page   = c.page;
		r.column = c.column;
		r.row    = c.row;
		r.last   = 1'b0;
		return r;
	endfunction

	// Put a charge on the open line, closing it first if the charge overflows
	function automatic place_t place_fn(input logic [7:0] used,
			input logic [INDEX_BITS-1:0] ostart, input logic [INDEX_BITS-1:0] start,
			input logic [8:0] charge, input logic [7:0] w);
		place_t     p;
		logic [7:0] u;
		logic [9:0] sum;
		p.emit       = (used != 8'd0) &&
			(({2'b00, used} + {1'b0, charge}) > {2'b00, w});
		p.emit_start = ostart;
		p.emit_len   = used;
		u            = p.emit ? 8'd0 : used;
		p.line_start = (u == 8'd0) ? start : ostart;
		sum          = {2'b00, u} + {1'b0, charge};
		p.used       = (sum > 10'd255) ? 8'd255 : sum[7:0];
		return p;
	endfunction

endpackage

[rtl/core/greedy_word_wrap_paginator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap_paginator_unit
// Takes one text character per request and lays words out greedily into
// lines, columns and pages, returning one record for each closed line. A
// character is taken once earlier records are gone or leaving; its records
// are held in a three-entry output register that drains one record per cycle
// while the sink is ready, so characters that close at most one line stream
// at one per cycle; one that closes two or three lines holds off the next
// while its records drain. Layout registers are to be written by the user
// over APB only while no text is in flight; the block does not enforce
// this. Line width at 0x0, lines per column at 0x4, columns per page at 0x8.
// ----------------------------------------------------------------------------
module greedy_word_wrap_paginator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [3:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	// character requests
	input  logic                            char_valid,
	output logic                            char_ready,
	input  logic [15:0]                     char_code,
	input  logic                            end_of_text,
	// line record requests
	output logic                            rec_valid,
	input  logic                            rec_ready,
	output logic [gwwp_pkg::INDEX_BITS-1:0] line_start,
	output logic [7:0]                      line_chars,
	output logic [gwwp_pkg::PAGE_BITS-1:0]  page_number,
	output logic [3:0]                      column_number,
	output logic [7:0]                      row_number,
	output logic                            last_record
);

	logic [7:0]       line_width_q;
	logic [7:0]       lines_per_column_q;
	logic [4:0]       columns_per_page_q;
	gwwp_pkg::state_t state_q;
	gwwp_pkg::state_t state_nxt;
	gwwp_pkg::rec_t   step_recs [3];
	logic [1:0]       step_count;
	gwwp_pkg::rec_t   rec_q [3];
	logic [1:0]       rec_cnt_q;
	logic [1:0]       rec_idx_q;
	gwwp_pkg::rec_t   rec_head;
	logic             char_acc;
	logic             rec_pop;
	logic             rec_last_pop;

	// Register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q       <= gwwp_pkg::RST_LINE_WIDTH;
			lines_per_column_q <= gwwp_pkg::RST_LINES_PER_COLUMN;
			columns_per_page_q <= gwwp_pkg::RST_COLUMNS_PER_PAGE;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				gwwp_pkg::REG_LINE_WIDTH:       line_width_q       <= pwdata[7:0];
				gwwp_pkg::REG_LINES_PER_COLUMN: lines_per_column_q <= pwdata[7:0];
				gwwp_pkg::REG_COLUMNS_PER_PAGE: columns_per_page_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			gwwp_pkg::REG_LINE_WIDTH:       prdata = 32'(line_width_q);
			gwwp_pkg::REG_LINES_PER_COLUMN: prdata = 32'(lines_per_column_q);
			gwwp_pkg::REG_COLUMNS_PER_PAGE: prdata = 32'(columns_per_page_q);
			default:                        prdata = 32'd0;
		endcase
	end

	// Layout of one character
	gwwp_step u_step (
		.st               (state_q),
		.char_code        (char_code),
		.end_of_text      (end_of_text),
		.line_width       (line_width_q),
		.lines_per_column (lines_per_column_q),
		.columns_per_page (columns_per_page_q),
		.nxt              (state_nxt),
		.recs             (step_recs),
		.rec_count        (step_count)
	);

	// Handshakes: take a character once the held records are gone or leaving
	assign rec_valid    = rec_idx_q < rec_cnt_q;
	assign rec_pop      = rec_valid && rec_ready;
	assign rec_last_pop = rec_pop && (rec_idx_q == (rec_cnt_q - 2'd1));
	assign char_ready   = !rec_valid || rec_last_pop;
	assign char_acc     = char_valid && char_ready;

	// Advance the layout state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (char_acc) begin
			state_q <= state_nxt;
		end
	end

	// Hold the records of the last character
	always_ff @(posedge clk) begin
		if (char_acc) begin
			rec_q <= step_recs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_cnt_q <= '0;
			rec_idx_q <= '0;
		end else if (char_acc) begin
			rec_cnt_q <= step_count;
			rec_idx_q <= '0;
		end else if (rec_last_pop) begin
			rec_cnt_q <= '0;
			rec_idx_q <= '0;
		end else if (rec_pop) begin
			rec_idx_q <= rec_idx_q + 2'd1;
		end
	end

	// Drive the record fields
	assign rec_head      = rec_q[rec_idx_q];
	assign line_start    = rec_head.start;
	assign line_chars    = rec_head.chars;
	assign page_number   = rec_head.page;
	assign column_number = rec_head.column;
	assign row_number    = rec_head.row;
	assign last_record   = rec_head.last;

	// Checks
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rec_valid |-> char_ready)
		else $error("character refused with no records held");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec_ready && last_record) |-> char_ready)
		else $error("final record leaving but character still held off");

	a_mid_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && !last_record) |-> !char_ready)
		else $error("character taken while records are still pending");

	a_empty_step: assert property (@(posedge clk) disable iff (!arst_n)
		(char_acc && (step_count == 2'd0)) |=> !rec_valid)
		else $error("record shown for a character that closed no line");

endmodule

[rtl/core/gwwp_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwp_step
// Next-state logic for one character: updates the word and line state and
// produces up to three line records with their page, column and row.
// ----------------------------------------------------------------------------
module gwwp_step (
	input  gwwp_pkg::state_t st,
	input  logic [15:0]      char_code,
	input  logic             end_of_text,
	input  logic [7:0]       line_width,
	input  logic [7:0]       lines_per_column,
	input  logic [4:0]       columns_per_page,
	output gwwp_pkg::state_t nxt,
	output gwwp_pkg::rec_t   recs [3],
	output logic [1:0]       rec_count
);

	logic [7:0]                      w;
	logic [7:0]                      rows;
	logic [4:0]                      cols;
	logic [7:0]                      used;
	logic [gwwp_pkg::INDEX_BITS-1:0] ostart;
	logic [gwwp_pkg::INDEX_BITS-1:0] wstart;
	logic [7:0]                      wchars;
	logic [gwwp_pkg::INDEX_BITS-1:0] pos;
	gwwp_pkg::ctr_t                  ctr;
	gwwp_pkg::place_t                pl;
	logic [1:0]                      n;

	// Clamp the layout registers to usable values
	always_comb begin
		w    = (line_width == 8'd0) ? 8'd1 : line_width;
		rows = (lines_per_column == 8'd0) ? 8'd1 : lines_per_column;
		if (columns_per_page == 5'd0) begin
			cols = 5'd1;
		end else if (columns_per_page > gwwp_pkg::MAX_COLUMNS) begin
			cols = gwwp_pkg::MAX_COLUMNS;
		end else begin
			cols = columns_per_page;
		end
	end

	// Lay out one character
	always_comb begin
		used   = st.open_line_used;
		ostart = st.open_line_start;
		wstart = st.word_start;
		wchars = st.word_chars;
		pos    = st.char_position;
		ctr    = st.ctr;
		n      = 2'd0;
		pl     = '0;
		for (int i = 0; i < 3; i++) begin
			recs[i] = '0;
		end

		if (char_code == gwwp_pkg::CHAR_SPACE) begin
			// space: place the pending word plus its separator
			pl = gwwp_pkg::place_fn(used, ostart, (wchars != 8'd0) ? wstart : pos,
				{1'b0, wchars} + 9'd1, w);
			if (pl.emit) begin
				recs[n] = gwwp_pkg::mk_rec(pl.emit_start, pl.emit_len, ctr);
				ctr     = gwwp_pkg::adv_ctr(ctr, rows, cols);
				n       = n + 2'd1;
			end
			used   = pl.used;
			ostart = pl.line_start;
			wchars = 8'd0;
		end else if (char_code == gwwp_pkg::CHAR_NEWLINE) begin
			// newline: place the pending word, then close the line
			if (wchars != 8'd0) begin
				pl = gwwp_pkg::place_fn(used, ostart, wstart, {1'b0, wchars} + 9'd1, w);
				if (pl.emit) begin
					recs[n] = gwwp_pkg::mk_rec(pl.emit_start, pl.emit_len, ctr);
					ctr     = gwwp_pkg::adv_ctr(ctr, rows, cols);
					n       = n + 2'd1;
				end
				used   = pl.used;
				ostart = pl.line_start;
				wchars = 8'd0;
			end
			recs[n] = gwwp_pkg::mk_rec((used != 8'd0) ? ostart : pos, used, ctr);
			ctr     = gwwp_pkg::adv_ctr(ctr, rows, cols);
			n       = n + 2'd1;
			used    = 8'd0;
		end else begin
			// word character: grow the word, cut it at full width
			if (wchars == 8'd0) begin
				wstart = pos;
			end
			wchars = wchars + 8'd1;
			if (wchars >= w) begin
				if (used != 8'd0) begin
					recs[n] = gwwp_pkg::mk_rec(ostart, used, ctr);
					ctr     = gwwp_pkg::adv_ctr(ctr, rows, cols);
					n       = n + 2'd1;
					used    = 8'd0;
				end
				recs[n] = gwwp_pkg::mk_rec(wstart, w, ctr);
				ctr     = gwwp_pkg::adv_ctr(ctr, rows, cols);
				n       = n + 2'd1;
				wstart  = wstart + gwwp_pkg::INDEX_BITS'(w);
				wchars  = wchars - w;
			end
		end

		// end of text: flush the word and the open line
		if (end_of_text) begin
			if (wchars != 8'd0) begin
				pl = gwwp_pkg::place_fn(used, ostart, wstart, {1'b0, wchars} + 9'd1, w);
				if (pl.emit) begin
					recs[n] = gwwp_pkg::mk_rec(pl.emit_start, pl.emit_len, ctr);
					ctr     = gwwp_pkg::adv_ctr(ctr, rows, cols);
					n       = n + 2'd1;
				end
				used   = pl.used;
				ostart = pl.line_start;
				wchars = 8'd0;
			end
			if (used != 8'd0) begin
				recs[n] = gwwp_pkg::mk_rec(ostart, used, ctr);
				ctr     = gwwp_pkg::adv_ctr(ctr, rows, cols);
				n       = n + 2'd1;
				used    = 8'd0;
			end
		end

		// mark the final record of this character
		for (int i = 0; i < 3; i++) begin
			recs[i].last = (n != 2'd0) && (2'(i) == (n - 2'd1));
		end
	end

	// Pack the next state
	always_comb begin
		nxt.char_position   = pos + gwwp_pkg::INDEX_BITS'(1);
		nxt.open_line_start = ostart;
		nxt.open_line_used  = used;
		nxt.word_start      = wstart;
		nxt.word_chars      = wchars;
		nxt.ctr             = ctr;
		rec_count           = n;
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy word-wrap paginator. Text characters are
// queued by phase, sent through a valid/ready driver with random gaps, and
// laid out by a line predictor inside the bench. Each returned line record is
// compared field by field with the oldest predicted record. Layout registers
// are rewritten over APB between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic [15:0] code;
		logic        eot;
		logic        drain;
	} char_item_t;

	localparam int SETTLE_CYCLES = 10;
	localparam int NUM_PHASES    = 8;
	localparam int RANDOM_CHARS  = 25;

	logic clk = 1'b0;
	logic arst_n;

	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [3:0]                      paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;
	logic                            char_valid;
	logic                            char_ready;
	logic [15:0]                     char_code;
	logic                            end_of_text;
	logic                            rec_valid;
	logic                            rec_ready;
	logic [gwwp_pkg::INDEX_BITS-1:0] line_start;
	logic [7:0]                      line_chars;
	logic [gwwp_pkg::PAGE_BITS-1:0]  page_number;
	logic [3:0]                      column_number;
	logic [7:0]                      row_number;
	logic                            last_record;

	// Pending characters and expected line records
	char_item_t       char_q[$];
	gwwp_pkg::rec_t   line_q[$];
	int               mismatches = 0;

	// Layout copy kept by the bench
	logic [gwwp_pkg::INDEX_BITS-1:0] text_pos;
	logic [gwwp_pkg::INDEX_BITS-1:0] open_start;
	logic [7:0]                      open_used;
	logic [gwwp_pkg::INDEX_BITS-1:0] word_begin;
	logic [7:0]                      word_len;
	logic [gwwp_pkg::PAGE_BITS-1:0]  page_ctr;
	logic [3:0]                      column_ctr;
	logic [7:0]                      row_ctr;
	logic [7:0]                      cfg_width;
	logic [7:0]                      cfg_rows;
	logic [4:0]                      cfg_cols;
	int                              step_lines;

	// Handshake bookkeeping
	bit         char_took;
	char_item_t next_char;
	int         snd_gap  = 0;
	int         snd_calm = 0;
	int         rcv_stall = 0;
	int         rcv_calm  = 0;

	// Phase settings: width, rows per column, columns per page
	int phase_width[NUM_PHASES] = '{3, 1, 255, 0, 20, 8, 40, 12};
	int phase_rows[NUM_PHASES]  = '{2, 1, 255, 0, 3, 1, 7, 4};
	int phase_cols[NUM_PHASES]  = '{2, 1, 16, 0, 31, 3, 5, 16};

	greedy_word_wrap_paginator_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.char_valid    (char_valid),
		.char_ready    (char_ready),
		.char_code     (char_code),
		.end_of_text   (end_of_text),
		.rec_valid     (rec_valid),
		.rec_ready     (rec_ready),
		.line_start    (line_start),
		.line_chars    (line_chars),
		.page_number   (page_number),
		.column_number (column_number),
		.row_number    (row_number),
		.last_record   (last_record)
	);

	always #1 clk = ~clk;

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 96)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	// Close a line: record it at the current position, then advance the position
	function automatic void close_line(input logic [gwwp_pkg::INDEX_BITS-1:0] start,
			input logic [7:0] len);
		gwwp_pkg::rec_t r;
		int             rows;
		int             cols;
		rows = (cfg_rows == 8'd0) ? 1 : cfg_rows;
		cols = (cfg_cols == 5'd0) ? 1 :
			((cfg_cols > gwwp_pkg::MAX_COLUMNS) ? 16 : cfg_cols);
		r.start  = start;
		r.chars  = len;
		r.page   = page_ctr;
		r.column = column_ctr;
		r.row    = row_ctr;
		r.last   = 1'b0;
		line_q.push_back(r);
		step_lines++;
		row_ctr = row_ctr + 8'd1;
		if (row_ctr >= rows) begin
			row_ctr    = 8'd0;
			column_ctr = column_ctr + 4'd1;
			if (column_ctr >= cols) begin
				column_ctr = 4'd0;
				page_ctr   = page_ctr + gwwp_pkg::PAGE_BITS'(1);
			end
		end
	endfunction

	// Put a word charge on the open line, closing the line first on overflow
	function automatic void put_word(input logic [gwwp_pkg::INDEX_BITS-1:0] start,
			input int charge);
		int w;
		w = (cfg_width == 8'd0) ? 1 : cfg_width;
		if (open_used != 8'd0 && open_used + charge > w) begin
			close_line(open_start, open_used);
			open_used = 8'd0;
		end
		if (open_used == 8'd0)
			open_start = start;
		open_used = (open_used + charge > 255) ? 8'd255 : 8'(open_used + charge);
	endfunction

	// Lay out one accepted character and queue the line records it closes
	function automatic void layout_char(input logic [15:0] code, input logic eot);
		int                              w;
		logic [gwwp_pkg::INDEX_BITS-1:0] here;
		gwwp_pkg::rec_t                  r;
		here       = text_pos;
		w          = (cfg_width == 8'd0) ? 1 : cfg_width;
		step_lines = 0;
		if (code == gwwp_pkg::CHAR_SPACE) begin
			put_word((word_len != 8'd0) ? word_begin : here, word_len + 1);
			word_len = 8'd0;
		end else if (code == gwwp_pkg::CHAR_NEWLINE) begin
			if (word_len != 8'd0) begin
				put_word(word_begin, word_len + 1);
				word_len = 8'd0;
			end
			close_line((open_used != 8'd0) ? open_start : here, open_used);
			open_used = 8'd0;
		end else begin
			if (word_len == 8'd0)
				word_begin = here;
			word_len = word_len + 8'd1;
			// cut a full-width piece off the word
			if (word_len >= w) begin
				if (open_used != 8'd0) begin
					close_line(open_start, open_used);
					open_used = 8'd0;
				end
				close_line(word_begin, 8'(w));
				word_begin = word_begin + gwwp_pkg::INDEX_BITS'(w);
				word_len   = word_len - 8'(w);
			end
		end
		// flush on the final character
		if (eot) begin
			if (word_len != 8'd0) begin
				put_word(word_begin, word_len + 1);
				word_len = 8'd0;
			end
			if (open_used != 8'd0) begin
				close_line(open_start, open_used);
				open_used = 8'd0;
			end
		end
		text_pos = here + gwwp_pkg::INDEX_BITS'(1);
		if (step_lines > 0) begin
			r      = line_q.pop_back();
			r.last = 1'b1;
			line_q.push_back(r);
		end
	endfunction

	function automatic logic [15:0] word_char();
		logic [15:0] c;
		if ($urandom_range(1) == 0)
			c = 16'($urandom_range(97, 122));
		else
			c = 16'($urandom_range(0, 65535));
		if (c == gwwp_pkg::CHAR_SPACE || c == gwwp_pkg::CHAR_NEWLINE)
			c = c ^ 16'h0100;
		return c;
	endfunction

	function automatic void queue_char(input logic [15:0] code, input logic eot,
			input logic drain);
		char_item_t it;
		it.code  = code;
		it.eot   = eot;
		it.drain = drain;
		char_q.push_back(it);
	endfunction

	// Queue random text: words, spaces, newlines, long runs and flushes
	task automatic queue_text(input int count, input logic drain_first);
		int          k;
		int          run;
		int          pick;
		logic [15:0] code;
		k = 0;
		while (k < count) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				run = (cfg_width == 8'd0) ? 1 : cfg_width;
				if (run > 40)
					run = 40;
				run = run + $urandom_range(0, 3);
				repeat (run)
					queue_char(word_char(), 1'b0, 1'b0);
				k = k + run;
			end else begin
				if (pick < 18)
					code = gwwp_pkg::CHAR_SPACE;
				else if (pick < 24)
					code = gwwp_pkg::CHAR_NEWLINE;
				else
					code = word_char();
				queue_char(code, $urandom_range(99) < 3,
					(k == 0 && drain_first) || $urandom_range(149) == 0);
				k++;
			end
		end
	endtask

	// Write a layout register, then read it back
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val,
			input logic [31:0] mask);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== (val & mask)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register %0d readback: expected %0h, got %0h", idx, val & mask,
					prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_layout(input int w, input int rows, input int cols);
		write_reg(gwwp_pkg::REG_LINE_WIDTH, 32'(w), 32'hFF);
		write_reg(gwwp_pkg::REG_LINES_PER_COLUMN, 32'(rows), 32'hFF);
		write_reg(gwwp_pkg::REG_COLUMNS_PER_PAGE, 32'(cols), 32'h1F);
		cfg_width = 8'(w);
		cfg_rows  = 8'(rows);
		cfg_cols  = 5'(cols);
	endtask

	// Hold until every character is taken and every record is back, then settle
	task automatic wait_drained();
		do
			@(posedge clk);
		while (char_q.size() != 0 || char_valid || line_q.size() != 0);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Character driver: hold until taken, idle for the chosen gap, then offer next
	always @(negedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_took) begin
				// hold the request
			end else if (snd_gap > 0) begin
				char_valid <= 1'b0;
				snd_gap--;
			end else if (char_q.size() != 0 &&
					!(char_q[0].drain && line_q.size() != 0)) begin
				next_char   = char_q.pop_front();
				char_code   <= next_char.code;
				end_of_text <= next_char.eot;
				char_valid  <= 1'b1;
				if (snd_calm > 0) begin
					snd_calm--;
					snd_gap = 0;
				end else begin
					snd_gap = pick_gap();
					if ($urandom_range(39) == 0)
						snd_calm = $urandom_range(20, 60);
				end
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// Record sink: stall at random with calm stretches
	always @(negedge clk) begin
		if (rcv_stall > 0) begin
			rec_ready <= 1'b0;
			rcv_stall--;
		end else begin
			rec_ready <= 1'b1;
			if (rcv_calm > 0) begin
				rcv_calm--;
			end else begin
				rcv_stall = pick_gap();
				if ($urandom_range(39) == 0)
					rcv_calm = $urandom_range(20, 60);
			end
		end
	end

	// Monitor: predict on each taken character, check each returned record
	always @(posedge clk) begin
		gwwp_pkg::rec_t want;
		char_took = arst_n && char_valid && char_ready;
		if (char_took)
			layout_char(char_code, end_of_text);
		if (arst_n && rec_valid && rec_ready) begin
			if (line_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"unexpected line record: start=%0d chars=%0d page=%0d",
						" col=%0d row=%0d last=%0d"},
						line_start, line_chars, page_number, column_number, row_number,
						last_record);
			end else begin
				want = line_q.pop_front();
				if (line_start !== want.start || line_chars !== want.chars ||
						page_number !== want.page || column_number !== want.column ||
						row_number !== want.row || last_record !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"line record mismatch: expected start=%0d chars=%0d",
							" page=%0d col=%0d row=%0d last=%0d, got start=%0d",
							" chars=%0d page=%0d col=%0d row=%0d last=%0d"},
							want.start, want.chars, want.page, want.column, want.row,
							want.last, line_start, line_chars, page_number,
							column_number, row_number, last_record);
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		char_valid  = 1'b0;
		char_code   = '0;
		end_of_text = 1'b0;
		rec_ready   = 1'b0;
		arst_n      = 1'b0;
		text_pos    = '0;
		open_start  = '0;
		open_used   = '0;
		word_begin  = '0;
		word_len    = '0;
		page_ctr    = '0;
		column_ctr  = '0;
		row_ctr     = '0;
		cfg_width   = gwwp_pkg::RST_LINE_WIDTH;
		cfg_rows    = gwwp_pkg::RST_LINES_PER_COLUMN;
		cfg_cols    = gwwp_pkg::RST_COLUMNS_PER_PAGE;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed text at reset layout: short words, code extremes, empty lines
		queue_char(16'd97, 1'b0, 1'b0);
		queue_char(16'd97, 1'b0, 1'b0);
		queue_char(gwwp_pkg::CHAR_SPACE, 1'b0, 1'b0);
		queue_char(16'hFFFF, 1'b0, 1'b0);
		queue_char(16'h0000, 1'b0, 1'b0);
		queue_char(gwwp_pkg::CHAR_SPACE, 1'b0, 1'b0);
		queue_char(gwwp_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
		queue_char(gwwp_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
		// full-width word followed directly by a space
		repeat (10)
			queue_char(16'd98, 1'b0, 1'b0);
		queue_char(gwwp_pkg::CHAR_SPACE, 1'b0, 1'b0);
		queue_char(gwwp_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
		queue_char(16'd122, 1'b1, 1'b0);
		queue_char(gwwp_pkg::CHAR_NEWLINE, 1'b1, 1'b0);
		queue_char(gwwp_pkg::CHAR_SPACE, 1'b1, 1'b0);
		// leave a word pending across the width change
		repeat (6)
			queue_char(16'd113, 1'b0, 1'b0);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_layout(phase_width[p], phase_rows[p], phase_cols[p]);
			// pending word now too long for the narrower line
			if (p == 0)
				queue_char(gwwp_pkg::CHAR_SPACE, 1'b0, 1'b0);
			queue_text(RANDOM_CHARS, p == 1);
			// widest line: one full-width cut, then a long word left pending
			if (p == 2)
				repeat (296)
					queue_char(word_char(), 1'b0, 1'b0);
			wait_drained();
		end

		mismatches = mismatches + line_q.size();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
